// ----- hw/rtl/utf8_stream_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define UTF8SD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UTF8SD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/utf8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8sd_pkg
// shared widths, status codes and result type of the utf8 stream decoder
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned SEQ_OFF_W = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_ZERO     = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0]      code_point;
        status_t              status;
        logic [LEN_W-1:0]     seq_length;
        logic [SEQ_OFF_W-1:0] seq_offset;
        logic                 is_final;
    } result_t;

endpackage

// ----- hw/rtl/utf8sd_byte_if.sv -----
// ----------------------------------------------------------------------------
// utf8sd_byte_if
// valid/ready channel carrying one stream byte and its end-of-stream mark
// ----------------------------------------------------------------------------
interface utf8sd_byte_if;
    import utf8sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

// ----- hw/rtl/utf8sd_result_if.sv -----
// ----------------------------------------------------------------------------
// utf8sd_result_if
// valid/ready channel carrying one decoded code point or error report
// ----------------------------------------------------------------------------
interface utf8sd_result_if;
    import utf8sd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CP_W-1:0]      code_point;
    logic [STATUS_W-1:0]  status;
    logic [LEN_W-1:0]     seq_length;
    logic [SEQ_OFF_W-1:0] seq_offset;
    logic                 is_final;

    modport source (
        output valid, output code_point, output status, output seq_length,
        output seq_offset, output is_final, input ready
    );
    modport sink (
        input valid, input code_point, input status, input seq_length,
        input seq_offset, input is_final, output ready
    );
endinterface

// ----- hw/rtl/utf8_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// decodes a utf-8 byte stream into code points with error reports
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | accept
//  ---------+-----+--------------------------------------------------+------------
//  stream   | in  | data_byte, stream_end                            | valid&ready
//  result   | out | code_point, status, seq_length, seq_offset,      | valid&ready
//           |     | is_final                                         |
//
//  one byte per cycle sustained while the skid register is empty; each result
//  is written into the output register, or into the skid register on a stall
//  the sequence state updates in the same cycle the byte is taken, so the
//  next byte sees it at once; the cycle is set by the lead-byte decode and
//  the 21-bit payload shift feeding the result register
//  a skid register behind the output register keeps stream.ready high while
//  one result waits; ready drops only when both hold results
//  rst_n clears sequence state, byte offset, discard flag and output valids
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_unit_macros.svh"

module utf8_stream_decoder_unit #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    utf8sd_byte_if.sink             stream,
    utf8sd_result_if.source         result
);
    import utf8sd_pkg::*;

    // decoder state
    logic [CP_W-1:0]        partial_reg,   partial_next;
    logic [1:0]             remain_reg,    remain_next;
    logic [LEN_W-1:0]       exp_len_reg,   exp_len_next;
    logic [OFFSET_BITS-1:0] pos_reg,       pos_next;
    logic [OFFSET_BITS-1:0] start_reg,     start_next;
    logic                   discard_reg,   discard_next;

    // output register and skid stage
    result_t                out_reg;
    logic                   out_valid_reg;
    result_t                skid_reg;
    logic                   skid_valid_reg;

    logic                   in_fire;
    logic                   out_fire;
    logic                   res_valid;
    result_t                res;
    logic                   err;
    logic [CP_W-1:0]        cont_value;
    logic [OFFSET_BITS+SEQ_OFF_W-1:0] start_ext;

    assign stream.ready = !skid_valid_reg;
    assign in_fire      = stream.valid && stream.ready;
    assign out_fire     = out_valid_reg && result.ready;

    // continuation payload appended below what has been gathered
    assign cont_value = {partial_reg[CP_W-7:0], stream.data_byte[5:0]};

    // offset counter may be narrower or wider than the reported field
    assign start_ext = {{SEQ_OFF_W{1'b0}}, start_next};

    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        exp_len_next = exp_len_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        discard_next = discard_reg;
        res_valid    = 1'b0;
        err          = 1'b0;
        res.code_point = '0;
        res.status     = ST_OK;
        res.seq_length = '0;
        res.is_final   = stream.stream_end;

        if (in_fire)
        begin
            if (discard_reg)
            begin
                // byte dropped until end of stream
            end
            else if (remain_reg == 2'd0)
            begin
                // lead byte
                start_next = pos_reg;
                casez (stream.data_byte)
                    8'b0???????:
                    begin
                        res_valid      = 1'b1;
                        res.seq_length = 3'd1;
                        if (stream.data_byte == '0)
                        begin
                            res.status = ST_ZERO;
                            err        = 1'b1;
                        end
                        else
                        begin
                            res.code_point = {{(CP_W-BYTE_W){1'b0}}, stream.data_byte};
                        end
                    end
                    8'b110?????:
                    begin
                        partial_next = {{(CP_W-5){1'b0}}, stream.data_byte[4:0]};
                        exp_len_next = 3'd2;
                        remain_next  = 2'd1;
                    end
                    8'b1110????:
                    begin
                        partial_next = {{(CP_W-4){1'b0}}, stream.data_byte[3:0]};
                        exp_len_next = 3'd3;
                        remain_next  = 2'd2;
                    end
                    8'b11110???:
                    begin
                        partial_next = {{(CP_W-3){1'b0}}, stream.data_byte[2:0]};
                        exp_len_next = 3'd4;
                        remain_next  = 2'd3;
                    end
                    default:
                    begin
                        // stray continuation or five or more leading ones
                        res_valid      = 1'b1;
                        res.status     = ST_BAD_LEAD;
                        res.seq_length = 3'd1;
                        err            = 1'b1;
                    end
                endcase
                // multi-byte lead on the last byte is cut short
                if (!res_valid && stream.stream_end)
                begin
                    res_valid      = 1'b1;
                    res.status     = ST_TRUNC;
                    res.seq_length = exp_len_next;
                end
            end
            else if (stream.data_byte[7:6] != 2'b10)
            begin
                // bad continuation byte is consumed
                res_valid      = 1'b1;
                res.status     = ST_BAD_CONT;
                res.seq_length = exp_len_reg;
                err            = 1'b1;
                remain_next    = 2'd0;
            end
            else
            begin
                partial_next = cont_value;
                remain_next  = remain_reg - 2'd1;
                if (remain_reg == 2'd1)
                begin
                    res_valid      = 1'b1;
                    res.seq_length = exp_len_reg;
                    if (cont_value == '0)
                    begin
                        res.status = ST_ZERO;
                        err        = 1'b1;
                    end
                    else
                    begin
                        res.code_point = cont_value;
                    end
                end
                else if (stream.stream_end)
                begin
                    res_valid      = 1'b1;
                    res.status     = ST_TRUNC;
                    res.seq_length = exp_len_reg;
                end
            end

            if (err)
            begin
                discard_next = 1'b1;
            end

            // end of stream restarts everything at offset zero
            if (stream.stream_end)
            begin
                pos_next     = '0;
                remain_next  = 2'd0;
                partial_next = '0;
                exp_len_next = '0;
                discard_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        res.seq_offset = start_ext[SEQ_OFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
            exp_len_reg <= '0;
            pos_reg     <= '0;
            start_reg   <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            exp_len_reg <= exp_len_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            discard_reg <= discard_next;
        end
    end

    // output valids; skid only fills while the output register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.code_point = out_reg.code_point;
    assign result.status     = out_reg.status;
    assign result.seq_length = out_reg.seq_length;
    assign result.seq_offset = out_reg.seq_offset;
    assign result.is_final   = out_reg.is_final;

    `UTF8SD_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid holds an item while the output register is empty")
    `UTF8SD_ASSERT_IMPL(a_discard_idle, clk, rst_n, discard_reg, remain_reg == 2'd0,
        "continuation bytes still expected while discarding")
    `UTF8SD_ASSERT_IMPL(a_remain_len, clk, rst_n, remain_reg != 2'd0,
        exp_len_reg > {1'b0, remain_reg},
        "remaining continuation count not below expected length")
    `UTF8SD_ASSERT_IMPL(a_err_zero_cp, clk, rst_n,
        out_valid_reg && (out_reg.status != ST_OK), out_reg.code_point == '0,
        "error result carries a nonzero code point")

endmodule

// ----- tb/utf8sd_checker.sv -----
// ----------------------------------------------------------------------------
// utf8sd_checker
// watches both channels, decodes every taken byte on its own and compares
// each result item, field by field, with the oldest decode still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_checker #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    utf8sd_byte_if      stream,
    utf8sd_result_if    result,
    output int unsigned fail_count,
    output int unsigned open_count
);
    import utf8sd_pkg::*;

    localparam int unsigned PRINT_CAP = 50;

    // decoder state as seen from the byte stream
    logic [CP_W-1:0]        partial_cp;
    logic [1:0]             conts_left;
    logic [LEN_W-1:0]       seq_len;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [OFFSET_BITS-1:0] lead_offset;
    logic                   dropping;

    result_t     owed_results[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        begin
            if (mismatches < PRINT_CAP)
                $display("%0t ns: %s", $time, msg);
            mismatches++;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    // one taken byte: update the state and queue the result it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        result_t                r;
        int unsigned            ones;
        logic                   emit;
        logic                   fault;
        logic [OFFSET_BITS-1:0] here;
        begin
            here         = next_offset;
            emit         = 1'b0;
            fault        = 1'b0;
            r.code_point = '0;
            r.status     = ST_OK;
            r.seq_length = '0;
            r.is_final   = fin;

            if (dropping) begin
                // byte swallowed after an error
            end else if (conts_left == 2'd0) begin
                casez (b)
                    8'b0???????: ones = 0;
                    8'b10??????: ones = 1;
                    8'b110?????: ones = 2;
                    8'b1110????: ones = 3;
                    8'b11110???: ones = 4;
                    default:     ones = 5;
                endcase
                lead_offset = here;
                if (ones == 0) begin
                    emit         = 1'b1;
                    r.seq_length = 3'd1;
                    if (b == 8'h00) begin
                        r.status = ST_ZERO;
                        fault    = 1'b1;
                    end else begin
                        r.code_point = CP_W'(b);
                    end
                end else if (ones == 1 || ones == 5) begin
                    emit         = 1'b1;
                    fault        = 1'b1;
                    r.status     = ST_BAD_LEAD;
                    r.seq_length = 3'd1;
                end else begin
                    case (ones)
                        2:       partial_cp = CP_W'(b[4:0]);
                        3:       partial_cp = CP_W'(b[3:0]);
                        default: partial_cp = CP_W'(b[2:0]);
                    endcase
                    seq_len    = LEN_W'(ones);
                    conts_left = 2'(ones - 1);
                    if (fin) begin
                        emit         = 1'b1;
                        r.status     = ST_TRUNC;
                        r.seq_length = seq_len;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                emit         = 1'b1;
                fault        = 1'b1;
                r.status     = ST_BAD_CONT;
                r.seq_length = seq_len;
                conts_left   = 2'd0;
            end else begin
                partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0) begin
                    emit         = 1'b1;
                    r.seq_length = seq_len;
                    if (partial_cp == '0) begin
                        r.status = ST_ZERO;
                        fault    = 1'b1;
                    end else begin
                        r.code_point = partial_cp;
                    end
                end else if (fin) begin
                    emit         = 1'b1;
                    r.status     = ST_TRUNC;
                    r.seq_length = seq_len;
                end
            end

            r.seq_offset = SEQ_OFF_W'(lead_offset);
            if (fault)
                dropping = 1'b1;

            if (fin) begin
                next_offset = '0;
                conts_left  = 2'd0;
                partial_cp  = '0;
                seq_len     = '0;
                dropping    = 1'b0;
            end else begin
                next_offset = here + 1'b1;
            end

            if (emit)
                owed_results.push_back(r);
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (!rst_n) begin
            partial_cp  = '0;
            conts_left  = 2'd0;
            seq_len     = '0;
            next_offset = '0;
            lead_offset = '0;
            dropping    = 1'b0;
        end else begin
            // results are registered, so one leaving now never comes from this byte; compare first
            if (result.valid && result.ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, code point 0x%0h status %0d",
                                              result.code_point, result.status));
                end else begin
                    want = owed_results.pop_front();
                    check_field("code_point", 32'(result.code_point), 32'(want.code_point));
                    check_field("status", 32'(result.status), 32'(want.status));
                    check_field("seq_length", 32'(result.seq_length), 32'(want.seq_length));
                    check_field("seq_offset", 32'(result.seq_offset), 32'(want.seq_offset));
                    check_field("is_final", 32'(result.is_final), 32'(want.is_final));
                end
            end
            if (stream.valid && stream.ready)
                decode_byte(stream.data_byte, stream.stream_end);
        end
        open_count <= owed_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives utf8_stream_decoder_unit with directed byte streams, a long output
// hold-off and random well-formed and broken streams; the checker beside
// the block scores every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned TAIL_CYCLES  = 8;

    // how often a generated sequence carries an all-zero payload
    localparam int unsigned ZERO_NEVER  = 0;
    localparam int unsigned ZERO_SOME   = 1;
    localparam int unsigned ZERO_ALWAYS = 2;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned open_count;
    int unsigned cycle_count   = 0;
    bit          gaps_on       = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;
    int unsigned items_counted = 0;
    logic [7:0]  byte_q[$];

    utf8sd_byte_if   stream_ch ();
    utf8sd_result_if result_ch ();

    utf8_stream_decoder_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    utf8sd_checker decode_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: a hang or a lost result ends here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, fully open while gaps are off, and a long
    // counted hold-off each time the stimulus asks for one
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (!gaps_on) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // offer one byte, with a random gap in front, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        begin
            while (gaps_on && $urandom_range(99) < 36) begin
                stream_ch.valid <= 1'b0;
                @(posedge clk);
            end
            stream_ch.valid      <= 1'b1;
            stream_ch.data_byte  <= b;
            stream_ch.stream_end <= fin;
            @(posedge clk);
            while (!stream_ch.ready)
                @(posedge clk);
        end
    endtask

    // send the queued bytes, marking the last as end of stream if asked;
    // bytes the block will only drop are left out of the item count
    task automatic send_queue(input logic fin_last, input int unsigned uncounted);
        logic [7:0] b;
        begin
            items_counted += byte_q.size() - uncounted;
            while (byte_q.size() > 0) begin
                b = byte_q.pop_front();
                send_byte(b, fin_last && (byte_q.size() == 0));
            end
        end
    endtask

    // queue one well-formed sequence of len bytes with random payload
    task automatic push_seq(input int unsigned len, input int unsigned zero_mode);
        logic        z;
        int unsigned i;
        begin
            z = (zero_mode == ZERO_ALWAYS) ||
                (zero_mode == ZERO_SOME && $urandom_range(11) == 0);
            case (len)
                1:       byte_q.push_back({1'b0, z ? 7'd0 : 7'($urandom)});
                2:       byte_q.push_back({3'b110, z ? 5'd0 : 5'($urandom)});
                3:       byte_q.push_back({4'b1110, z ? 4'd0 : 4'($urandom)});
                default: byte_q.push_back({5'b11110, z ? 3'd0 : 3'($urandom)});
            endcase
            for (i = 1; i < len; i++)
                byte_q.push_back({2'b10, z ? 6'd0 : 6'($urandom)});
        end
    endtask

    initial begin
        int unsigned kind;
        int unsigned n;
        int unsigned len;
        int unsigned keep;
        int unsigned fill;
        logic [1:0]  top;

        stream_ch.valid      <= 1'b0;
        stream_ch.data_byte  <= 8'h00;
        stream_ch.stream_end <= 1'b0;
        rst_n                <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // two single-byte values, then the smallest and largest two-byte and the largest three-byte
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // largest 21-bit value, no range check in the block
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // stream ends in the middle of a sequence
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b1);
        // nul as the last byte of its stream
        send_byte(8'h00, 1'b1);
        // stray continuation byte as lead, rest of stream dropped silently
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // too many leading ones
        send_byte(8'hFF, 1'b1);
        // ascii where a continuation belongs, then a dropped tail
        send_byte(8'hC1, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        // overlong zero
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b1);
        // stream ends right on a lead byte
        send_byte(8'hF0, 1'b1);

        // ---- output hold-off: results back up until the input stalls ----
        hold_requests++;
        repeat (40)
            byte_q.push_back({1'b0, 7'($urandom_range(127, 1))});
        send_queue(1'b1, 0);

        // ---- random streams ----
        while (items_counted < RANDOM_ITEMS) begin
            // one stretch runs with no gaps on either side
            gaps_on = !(items_counted >= 500 && items_counted < 700);
            kind = $urandom_range(99);
            if (kind < 60) begin
                // well-formed stream
                n = $urandom_range(6, 1);
                repeat (n) push_seq($urandom_range(4, 1), ZERO_SOME);
                send_queue(1'b1, 0);
            end else if (kind < 72) begin
                // good sequences, then one cut short by the end mark
                n = $urandom_range(4, 0);
                repeat (n) push_seq($urandom_range(4, 1), ZERO_NEVER);
                len = $urandom_range(4, 2);
                keep = $urandom_range(len - 1, 1);
                push_seq(len, ZERO_SOME);
                repeat (len - keep) void'(byte_q.pop_back());
                send_queue(1'b1, 0);
            end else if (kind < 92) begin
                // good sequences, one error, then bytes that get dropped
                n = $urandom_range(3, 0);
                repeat (n) push_seq($urandom_range(4, 1), ZERO_NEVER);
                case ($urandom_range(2))
                    0: begin
                        if ($urandom_range(1))
                            byte_q.push_back({2'b10, 6'($urandom)});
                        else
                            byte_q.push_back({5'b11111, 3'($urandom)});
                    end
                    1: begin
                        len = $urandom_range(4, 2);
                        keep = $urandom_range(len - 2, 0);
                        push_seq(len, ZERO_NEVER);
                        repeat (len - 1 - keep) void'(byte_q.pop_back());
                        top = 2'($urandom_range(2));
                        if (top == 2'b10)
                            top = 2'b11;
                        byte_q.push_back({top, 6'($urandom)});
                    end
                    default: push_seq($urandom_range(4, 1), ZERO_ALWAYS);
                endcase
                fill = $urandom_range(4, 0);
                repeat (fill) byte_q.push_back(8'($urandom));
                send_queue(1'b1, fill);
            end else begin
                // raw noise
                n = $urandom_range(8, 1);
                repeat (n) byte_q.push_back(8'($urandom));
                send_queue(1'b1, 0);
            end
        end

        // let the checker see the last byte before waiting on owed results
        stream_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- utf8_stream_decoder_unit.f -----
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_byte_if.sv
hw/rtl/utf8sd_result_if.sv
hw/rtl/utf8_stream_decoder_unit.sv
tb/utf8sd_checker.sv
tb/tb_top.sv
